// ===== src/kpd_pkg.sv =====
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad scanner
// Column codes, operation codes and the result record of the scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int unsigned NUM_ROWS  = 4;
  localparam int unsigned COL_W     = 4;   // column samples per row
  localparam int unsigned COLNUM_W  = 3;   // column number 0..4
  localparam int unsigned KEY_W     = 5;   // key 0..16
  localparam int unsigned CNT_W     = 8;   // debounce counter / threshold

  // single-low-bit column patterns (active low, bit3 = column 1)
  localparam logic [COL_W-1:0] COLS_COL1 = 4'h7;
  localparam logic [COL_W-1:0] COLS_COL2 = 4'hb;
  localparam logic [COL_W-1:0] COLS_COL3 = 4'hd;
  localparam logic [COL_W-1:0] COLS_COL4 = 4'he;

  localparam logic [CNT_W-1:0] COUNT_MAX       = 8'd255;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd3;
  localparam logic [KEY_W-1:0] KEY_NONE        = 5'd0;

  // item kind carried in tuser
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } kpd_op_t;

  typedef logic [COLNUM_W-1:0] kpd_colnum_t;
  typedef logic [KEY_W-1:0]    kpd_key_t;

  // result of one item
  typedef struct packed {
    kpd_key_t stable_key;
    kpd_key_t event_key;
  } kpd_result_t;

endpackage : kpd_pkg

`default_nettype wire

// ===== src/kpd_row_lane.sv =====
// ----------------------------------------------------------------------------
// kpd_row_lane: column decoder for one keypad row
// Returns the column number 1..4 for exactly one low bit, 0 otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_row_lane (
  input  wire logic [kpd_pkg::COL_W-1:0] cols,
  output kpd_pkg::kpd_colnum_t           col_num
);

  // single-press decode
  always_comb begin
    case (cols)
      kpd_pkg::COLS_COL1: col_num = 3'd1;
      kpd_pkg::COLS_COL2: col_num = 3'd2;
      kpd_pkg::COLS_COL3: col_num = 3'd3;
      kpd_pkg::COLS_COL4: col_num = 3'd4;
      default:            col_num = 3'd0;
    endcase
  end

endmodule : kpd_row_lane

`default_nettype wire

// ===== src/kpd_key_merge.sv =====
// ----------------------------------------------------------------------------
// kpd_key_merge: row-priority merge of the lane results
// First row with a single press wins; key = 4*(row-1)+column, 0 if none.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_key_merge (
  input  wire kpd_pkg::kpd_colnum_t col_num [kpd_pkg::NUM_ROWS],
  output kpd_pkg::kpd_key_t         raw_key
);

  // scan from the last row down so the first row ends up on top
  always_comb begin
    raw_key = kpd_pkg::KEY_NONE;
    for (int r = kpd_pkg::NUM_ROWS - 1; r >= 0; r--) begin
      if (col_num[r] != 3'd0) begin
        raw_key = {1'b0, 2'(r), 2'b00} + {2'b00, col_num[r]};
      end
    end
  end

endmodule : kpd_key_merge

`default_nettype wire

// ===== src/kpd_debounce.sv =====
// ----------------------------------------------------------------------------
// kpd_debounce: debounce state, threshold register and pending event
// Updates the state for each accepted item and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_debounce (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [kpd_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire logic                      fire,      // item accepted
  input  wire kpd_pkg::kpd_op_t          op,
  input  wire kpd_pkg::kpd_key_t         raw_key,
  output kpd_pkg::kpd_result_t           result     // valid with fire
);

  logic [kpd_pkg::CNT_W-1:0] thresh_r;
  kpd_pkg::kpd_key_t         prev_raw_r, prev_raw_nxt;
  kpd_pkg::kpd_key_t         deb_r, deb_nxt;
  kpd_pkg::kpd_key_t         pend_r, pend_nxt;
  logic [kpd_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  kpd_pkg::kpd_key_t         event_key;

  // next-state logic for one item
  always_comb begin
    prev_raw_nxt = prev_raw_r;
    deb_nxt      = deb_r;
    pend_nxt     = pend_r;
    cnt_nxt      = cnt_r;
    event_key    = kpd_pkg::KEY_NONE;
    if (op == kpd_pkg::OP_TICK) begin
      if (raw_key == prev_raw_r) begin
        if (cnt_r < kpd_pkg::COUNT_MAX) begin
          cnt_nxt = cnt_r + 8'd1;
        end
        if ((cnt_nxt >= thresh_r) && (deb_r != prev_raw_r)) begin
          deb_nxt = prev_raw_r;
          if (prev_raw_r != kpd_pkg::KEY_NONE) begin
            pend_nxt = prev_raw_r;
          end
        end
      end else begin
        prev_raw_nxt = raw_key;
        cnt_nxt      = 8'd1;
      end
    end else begin
      event_key = pend_r;
      pend_nxt  = kpd_pkg::KEY_NONE;
    end
  end

  assign result.event_key  = event_key;
  assign result.stable_key = deb_nxt;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= kpd_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  // debounce state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= kpd_pkg::KEY_NONE;
      deb_r      <= kpd_pkg::KEY_NONE;
      pend_r     <= kpd_pkg::KEY_NONE;
      cnt_r      <= '0;
    end else if (fire) begin
      prev_raw_r <= prev_raw_nxt;
      deb_r      <= deb_nxt;
      pend_r     <= pend_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // stable key moves only on an accepted tick
  a_deb_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(deb_r) |-> $past(fire && (op == kpd_pkg::OP_TICK)))
    else $error("stable key changed without a tick");

  // a read leaves no pending event
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (op == kpd_pkg::OP_READ)) |=> (pend_r == kpd_pkg::KEY_NONE))
    else $error("pending event survived a read");

  // zero count only before the first tick: all keys still clear
  a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> ((prev_raw_r == kpd_pkg::KEY_NONE) && (deb_r == kpd_pkg::KEY_NONE)))
    else $error("zero count with non-reset keys");

  // pending event mirrors a key that was stable; both keys stay within 0..16
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r <= 5'd16) && (deb_r <= 5'd16))
    else $error("key out of range");

endmodule : kpd_debounce

`default_nettype wire

// ===== src/keypad_scan_debouncer_top.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debouncer_top: 4x4 matrix keypad scanner with debounce
// Four row lanes decode the column samples, a merge picks the first row with
// a single press, and the debounce core tracks the stable key and event.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------
//   in_     | in  | tvalid/tready      | tdata: row1..row4 cols, tuser: op
//   out_    | out | tvalid/tready      | tdata: event_key, stable_key
//   cfg_    | in  | wr_en (no wait)    | wr_data: debounce threshold
//
// One item per cycle unless stalled; each result shows in the next cycle.
// Decode, merge and debounce update are one combinational step into the
// state registers and the output register.
// A stalled output holds its result; a new item is still taken in the cycle
// the output is drained. Reset (synchronous) clears state and sets the
// threshold to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_scan_debouncer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // row1_columns, row2_columns, row3_columns, row4_columns
  input  wire logic        in_tuser,   // operation
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // event_key, stable_key, 6'b0
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  kpd_pkg::kpd_colnum_t col_num [kpd_pkg::NUM_ROWS];
  kpd_pkg::kpd_key_t    raw_key;
  kpd_pkg::kpd_result_t result;
  kpd_pkg::kpd_result_t res_r;
  kpd_pkg::kpd_op_t     op;
  logic                 fire;
  logic                 out_valid_r;

  assign op        = kpd_pkg::kpd_op_t'(in_tuser);
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  // one decoder lane per row
  for (genvar r = 0; r < kpd_pkg::NUM_ROWS; r++) begin : g_lane
    kpd_row_lane u_lane (
      .cols    (in_tdata[r*kpd_pkg::COL_W +: kpd_pkg::COL_W]),
      .col_num (col_num[r])
    );
  end

  kpd_key_merge u_merge (
    .col_num (col_num),
    .raw_key (raw_key)
  );

  kpd_debounce u_deb (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .op          (op),
    .raw_key     (raw_key),
    .result      (result)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r.stable_key, res_r.event_key};

endmodule : keypad_scan_debouncer_top

`default_nettype wire

// ===== test/keypad_debounce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_debounce_checker: result checker for the keypad scanner
// Watches the item and result channels and the threshold writes. It keeps
// its own copy of the debounce state, predicts event_key and stable_key for
// every accepted item and compares each result against the oldest
// prediction.
// ----------------------------------------------------------------------------

module keypad_debounce_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // row1_columns, row2_columns, row3_columns, row4_columns
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // event_key, stable_key, 6'b0
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  output int          fail_count,
  output int          items_seen,
  output int          results_seen,
  output int          events_seen,
  output int          pending_count
);

  // predicted debounce state
  logic [kpd_pkg::CNT_W-1:0] threshold;
  logic [kpd_pkg::CNT_W-1:0] repeat_cnt;
  kpd_pkg::kpd_key_t         prev_raw;
  kpd_pkg::kpd_key_t         stable;
  kpd_pkg::kpd_key_t         pending_key;

  kpd_pkg::kpd_result_t expected_keys[$];

  // column number for a single low bit, 0 for none or several
  function automatic kpd_pkg::kpd_colnum_t column_of(
      input logic [kpd_pkg::COL_W-1:0] cols);
    case (cols)
      kpd_pkg::COLS_COL1: return kpd_pkg::kpd_colnum_t'(1);
      kpd_pkg::COLS_COL2: return kpd_pkg::kpd_colnum_t'(2);
      kpd_pkg::COLS_COL3: return kpd_pkg::kpd_colnum_t'(3);
      kpd_pkg::COLS_COL4: return kpd_pkg::kpd_colnum_t'(4);
      default:            return kpd_pkg::kpd_colnum_t'(0);
    endcase
  endfunction

  // first row with exactly one press wins
  function automatic kpd_pkg::kpd_key_t raw_key_of(input logic [15:0] cols);
    kpd_pkg::kpd_colnum_t c;
    for (int r = 0; r < kpd_pkg::NUM_ROWS; r++) begin
      c = column_of(cols[r*kpd_pkg::COL_W +: kpd_pkg::COL_W]);
      if (c != 0) return kpd_pkg::kpd_key_t'(4 * r + c);
    end
    return kpd_pkg::KEY_NONE;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // advance the predicted state by one item
  task automatic step_debounce(input kpd_pkg::kpd_op_t op, input logic [15:0] cols,
                               output kpd_pkg::kpd_result_t res);
    kpd_pkg::kpd_key_t raw;
    res.event_key = kpd_pkg::KEY_NONE;
    if (op == kpd_pkg::OP_TICK) begin
      raw = raw_key_of(cols);
      if (raw == prev_raw) begin
        if (repeat_cnt < kpd_pkg::COUNT_MAX) repeat_cnt++;
        if (repeat_cnt >= threshold && stable != prev_raw) begin
          stable = prev_raw;
          // a release raises no event
          if (stable != kpd_pkg::KEY_NONE) pending_key = stable;
        end
      end else begin
        // new raw key restarts the count
        prev_raw   = raw;
        repeat_cnt = 8'd1;
      end
    end else begin
      res.event_key = pending_key;
      pending_key   = kpd_pkg::KEY_NONE;
    end
    res.stable_key = stable;
  endtask

  always @(posedge clk) begin : watch
    kpd_pkg::kpd_result_t want;
    kpd_pkg::kpd_result_t got;
    if (!rst_n) begin
      threshold     = kpd_pkg::THRESHOLD_RESET;
      repeat_cnt    = '0;
      prev_raw      = kpd_pkg::KEY_NONE;
      stable        = kpd_pkg::KEY_NONE;
      pending_key   = kpd_pkg::KEY_NONE;
      fail_count    = 0;
      items_seen    = 0;
      results_seen  = 0;
      events_seen   = 0;
      expected_keys.delete();
    end else begin
      // results leave the cycle after their item or later, so compare first
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = kpd_pkg::kpd_result_t'(out_tdata[9:0]);
        if (got.event_key != kpd_pkg::KEY_NONE) events_seen++;
        if (expected_keys.size() == 0) begin
          report_mismatch($sformatf("result with no item waiting, tdata=%h", out_tdata));
        end else begin
          want = expected_keys.pop_front();
          if (got.event_key != want.event_key)
            report_mismatch($sformatf("result %0d event_key got %0d expected %0d",
                                      results_seen, got.event_key, want.event_key));
          if (got.stable_key != want.stable_key)
            report_mismatch($sformatf("result %0d stable_key got %0d expected %0d",
                                      results_seen, got.stable_key, want.stable_key));
          if (out_tdata[15:10] != '0)
            report_mismatch($sformatf("result %0d padding bits got %h",
                                      results_seen, out_tdata[15:10]));
        end
      end
      if (in_tvalid && in_tready) begin
        step_debounce(kpd_pkg::kpd_op_t'(in_tuser), in_tdata, want);
        expected_keys.push_back(want);
        items_seen++;
      end
      if (cfg_wr_en) threshold = cfg_wr_data;
    end
    pending_count = expected_keys.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the keypad scanner
// Runs a directed sequence of presses, releases, bounces and reads, then
// random key sequences under several debounce thresholds (0, 1, 2, 255 and
// one random value), with random gaps on the item side and random stalls on
// the result side. The checker predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '1;
  logic        in_tuser    = kpd_pkg::OP_TICK;
  logic        out_tvalid;
  logic        out_tready  = 1'b1;
  logic [15:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  int fail_count;
  int items_seen;
  int results_seen;
  int events_seen;
  int pending_count;

  bit         quiet       = 1'b0;   // no gaps and no new stalls while set
  int         stall_left  = 0;
  int         idle_cycles = 0;
  logic [7:0] threshold_now = kpd_pkg::THRESHOLD_RESET;

  always #5 clk = ~clk;

  keypad_scan_debouncer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  keypad_debounce_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .items_seen    (items_seen),
    .results_seen  (results_seen),
    .events_seen   (events_seen),
    .pending_count (pending_count)
  );

  // mostly short idle stretches, a few long ones
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (rst_n && !quiet && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      stall_left = idle_length() - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic bit is_single(input logic [3:0] v);
    return v inside {kpd_pkg::COLS_COL1, kpd_pkg::COLS_COL2,
                     kpd_pkg::COLS_COL3, kpd_pkg::COLS_COL4};
  endfunction

  // row sample that never qualifies: idle or several presses
  function automatic logic [3:0] dead_row();
    logic [3:0] v;
    if ($urandom_range(0, 99) < 60) return 4'hf;
    do v = 4'($urandom_range(0, 15)); while (is_single(v));
    return v;
  endfunction

  // column samples that decode to key (0 = no key); later rows random
  function automatic logic [15:0] key_columns(input int key);
    logic [15:0] cols;
    int row;
    int col;
    cols = 16'($urandom);
    if (key == 0) begin
      for (int r = 0; r < kpd_pkg::NUM_ROWS; r++)
        cols[r*kpd_pkg::COL_W +: kpd_pkg::COL_W] = dead_row();
    end else begin
      row = (key - 1) / 4;
      col = (key - 1) % 4;
      for (int r = 0; r < row; r++) cols[r*kpd_pkg::COL_W +: kpd_pkg::COL_W] = dead_row();
      cols[row*kpd_pkg::COL_W +: kpd_pkg::COL_W] = 4'hf ^ (4'h8 >> col);
    end
    return cols;
  endfunction

  task automatic send_item(input kpd_pkg::kpd_op_t op, input logic [15:0] cols);
    int gap;
    gap = (!quiet && $urandom_range(0, 99) < 35) ? idle_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cols;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_cols(input logic [15:0] cols, input int n);
    repeat (n) send_item(kpd_pkg::OP_TICK, cols);
  endtask

  task automatic hold_key(input int key, input int n);
    repeat (n) send_item(kpd_pkg::OP_TICK, key_columns(key));
  endtask

  // drain, then write the threshold while the block is idle
  task automatic write_threshold(input logic [7:0] v);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    threshold_now = v;
  endtask

  // random key sequences: clean holds, bounces, noise and reads
  task automatic run_phase(input int n);
    int sent;
    int r;
    int key;
    int len;
    int need;
    bit bounce;
    sent = 0;
    need = (threshold_now < 2) ? 2 : threshold_now;
    while (sent < n) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        send_item(kpd_pkg::OP_READ, 16'($urandom));
        sent++;
      end else if (r < 32) begin
        send_item(kpd_pkg::OP_TICK, 16'($urandom));
        sent++;
      end else begin
        key    = $urandom_range(0, 16);
        len    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, need)
                                             : need + $urandom_range(0, 2);
        if (len > 16) len = $urandom_range(1, 16);
        bounce = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          if (bounce && i == len / 2) begin
            send_item(kpd_pkg::OP_TICK, 16'($urandom));
            sent++;
          end
          send_item(kpd_pkg::OP_TICK, key_columns(key));
          sent++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset threshold of 3
    send_item(kpd_pkg::OP_READ, 16'h0000);      // nothing pending yet
    send_item(kpd_pkg::OP_TICK, 16'hffff);      // all idle
    send_item(kpd_pkg::OP_TICK, 16'h0000);      // every row has several presses
    hold_cols(16'hfff7, 3);            // key 1 taken on the third sample
    send_item(kpd_pkg::OP_READ, 16'h0000);      // columns ignored on a read
    send_item(kpd_pkg::OP_READ, 16'hffff);      // event already cleared
    hold_cols(16'heff3, 3);            // row 1 double press falls through to key 16
    hold_cols(16'hff7e, 3);            // key 4 overwrites the pending event
    hold_cols(16'hffff, 3);            // release, event stays pending
    send_item(kpd_pkg::OP_READ, 16'h1234);
    send_item(kpd_pkg::OP_TICK, 16'hfdff);      // key 11 once
    hold_cols(16'hffbf, 2);            // key 6 restarts the count
    send_item(kpd_pkg::OP_TICK, 16'hefff);      // key 16, again a restart

    write_threshold(8'd1);
    run_phase(70);
    write_threshold(8'd0);
    run_phase(70);

    // top of the range: a long hold also saturates the repeat count
    write_threshold(8'd255);
    hold_key($urandom_range(1, 16), 257);
    send_item(kpd_pkg::OP_READ, 16'($urandom));
    hold_key(0, 20);
    send_item(kpd_pkg::OP_READ, 16'($urandom));
    run_phase(30);

    write_threshold(8'd2);
    run_phase(70);
    write_threshold(8'($urandom_range(4, 12)));
    run_phase(70);

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (5) @(posedge clk);

    $display("covered %0d items and %0d results with %0d key events,", items_seen,
             results_seen, events_seen);
    $display("thresholds 3, 1, 0, 255, 2 and one random value");
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
